FILE: hw/rtl/coefficient_compress_pack_assert.svh
// assertion macros shared by the coefficient compress/pack rtl
// no dependencies; included by the modules that carry checks
`ifndef COEFFICIENT_COMPRESS_PACK_ASSERT_SVH
`define COEFFICIENT_COMPRESS_PACK_ASSERT_SVH
`ifndef SYNTHESIS
// clocked check, held off while reset is asserted
`define CCP_ASSERT_RST(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("ccp check failed");
// clocked check that also holds during reset
`define CCP_ASSERT(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("ccp check failed");
`else
`define CCP_ASSERT_RST(label, clk, rst_n, prop)
`define CCP_ASSERT(label, clk, prop)
`endif
`endif

FILE: hw/rtl/ccp_pkg.sv
// shared constants and types for the coefficient compress/pack block
// no dependencies
package ccp_pkg;

    // modulus and rounding offset
    localparam int unsigned Q_MOD     = 3329;
    localparam logic [21:0] HALF_Q    = 22'd1664;

    // coef + 32768 + 522 = coef + 10*q, always positive and congruent
    localparam logic [16:0] REDUCE_OFFSET = 17'd522;

    // exact floor(u / q) for u < 2^17: (u * RED_MUL) >> RED_SHIFT
    localparam logic [16:0] RED_MUL   = 17'd80636;
    localparam int unsigned RED_SHIFT = 28;

    // exact floor(n / q) for n < 2^22: (n * CMP_MUL) >> CMP_SHIFT
    localparam logic [22:0] CMP_MUL   = 23'd5160670;
    localparam int unsigned CMP_SHIFT = 34;

    localparam logic [2:0] BYTES_TEN  = 3'd5;
    localparam logic [2:0] BYTES_FOUR = 3'd1;
    localparam logic [1:0] SLOT_LAST  = 2'd3;

    // group handed from the packer to the byte serializer
    typedef struct packed {
        logic        valid;
        logic [2:0]  cnt;
        logic [39:0] data;
    } t_load;

endpackage

FILE: hw/rtl/ccp_modq.sv
// input register and reduction modulo q (quotient stage)
// depends on ccp_pkg
module ccp_modq (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_adv,
    input  logic        i_valid,
    input  logic [15:0] i_coefficient,
    output logic        o_valid,
    output logic [16:0] o_u,
    output logic [4:0]  o_q
);

    logic        r_s1_valid;
    logic [15:0] r_s1_coef;
    logic        r_s2_valid;
    logic [16:0] r_s2_u;
    logic [4:0]  r_s2_q;

    logic [16:0] n_u;
    logic [33:0] w_prod;

    // offset binary of the signed word, then move by 522 to reach coef + 10q
    assign n_u    = {1'b0, ~r_s1_coef[15], r_s1_coef[14:0]} + ccp_pkg::REDUCE_OFFSET;
    assign w_prod = 34'(n_u) * 34'(ccp_pkg::RED_MUL);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else if (i_adv) begin
            r_s1_valid <= i_valid;
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_s1_coef <= i_coefficient;
            r_s2_u    <= n_u;
            r_s2_q    <= w_prod[ccp_pkg::RED_SHIFT+4:ccp_pkg::RED_SHIFT];
        end
    end

    assign o_valid = r_s2_valid;
    assign o_u     = r_s2_u;
    assign o_q     = r_s2_q;

endmodule

FILE: hw/rtl/ccp_compress.sv
// remainder modulo q and rounded compression to 10 or 4 bits
// depends on ccp_pkg
module ccp_compress (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_adv,
    input  logic        i_valid,
    input  logic [16:0] i_u,
    input  logic [4:0]  i_q,
    input  logic        i_ten_bit_mode,
    output logic        o_valid,
    output logic [9:0]  o_c
);

    logic        r_valid;
    logic [9:0]  r_c;

    logic [16:0] w_rem;
    logic [11:0] w_t;
    logic [21:0] w_num;
    logic [44:0] w_prod;
    logic [9:0]  n_c;

    assign w_rem  = i_u - (17'(i_q) * 17'(ccp_pkg::Q_MOD));
    assign w_t    = w_rem[11:0];
    assign w_num  = i_ten_bit_mode ? ({w_t, 10'b0} + ccp_pkg::HALF_Q)
                                   : ({6'b0, w_t, 4'b0} + ccp_pkg::HALF_Q);
    assign w_prod = 45'(w_num) * 45'(ccp_pkg::CMP_MUL);

    // quotient can reach 2^d, the mask wraps it to zero
    assign n_c = i_ten_bit_mode ? w_prod[ccp_pkg::CMP_SHIFT+9:ccp_pkg::CMP_SHIFT]
                                : {6'b0, w_prod[ccp_pkg::CMP_SHIFT+3:ccp_pkg::CMP_SHIFT]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_c <= n_c;
        end
    end

    assign o_valid = r_valid;
    assign o_c     = r_c;

endmodule

FILE: hw/rtl/ccp_pack.sv
// gathers compressed values into groups of four (10-bit) or two (4-bit)
// depends on ccp_pkg
module ccp_pack (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_adv,
    input  logic          i_clear,
    input  logic          i_valid,
    input  logic [9:0]    i_c,
    input  logic          i_ten_bit_mode,
    output ccp_pkg::t_load o_load
);

    logic [1:0]  r_slot;
    logic [29:0] r_held;
    logic [1:0]  n_slot;
    logic [29:0] n_held;
    logic        w_complete;

    assign w_complete = i_ten_bit_mode ? (r_slot == ccp_pkg::SLOT_LAST) : r_slot[0];

    always_comb begin
        o_load = '0;
        if (i_valid && w_complete) begin
            o_load.valid = 1'b1;
            if (i_ten_bit_mode) begin
                o_load.cnt  = ccp_pkg::BYTES_TEN;
                o_load.data = {i_c, r_held};
            end else begin
                o_load.cnt  = ccp_pkg::BYTES_FOUR;
                o_load.data = {32'b0, i_c[3:0], r_held[3:0]};
            end
        end
    end

    always_comb begin
        n_slot = r_slot;
        n_held = r_held;
        if (w_complete) begin
            n_slot = 2'd0;
            n_held = '0;
        end else if (i_ten_bit_mode) begin
            n_slot = r_slot + 2'd1;
            unique case (r_slot)
                2'd0:    n_held = r_held | {20'b0, i_c};
                2'd1:    n_held = r_held | {10'b0, i_c, 10'b0};
                2'd2:    n_held = r_held | {i_c, 20'b0};
                default: n_held = r_held;
            endcase
        end else begin
            n_slot = 2'd1;
            n_held = {26'b0, i_c[3:0]};
        end
    end

    // a mode write drops any partial group
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_slot <= 2'd0;
            r_held <= '0;
        end else if (i_valid && i_adv) begin
            r_slot <= n_slot;
            r_held <= n_held;
        end
    end

endmodule

FILE: hw/rtl/ccp_serial.sv
// byte serializer: shifts a loaded group out one byte per accepted word
// depends on ccp_pkg and coefficient_compress_pack_assert.svh
`include "coefficient_compress_pack_assert.svh"

module ccp_serial (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  ccp_pkg::t_load i_load,
    output logic           o_can_load,
    output logic           o_valid,
    input  logic           i_stall,
    output logic [7:0]     o_packed_byte,
    output logic           o_group_end
);

    logic [2:0]  r_cnt;
    logic [39:0] r_data;
    logic        w_take;
    logic        w_load;

    assign o_valid    = (r_cnt != 3'd0);
    assign w_take     = o_valid && !i_stall;
    // a new group may land on the cycle the last byte leaves
    assign o_can_load = (r_cnt == 3'd0) || ((r_cnt == 3'd1) && !i_stall);
    assign w_load     = i_load.valid && o_can_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 3'd0;
        end else if (w_load) begin
            r_cnt <= i_load.cnt;
        end else if (w_take) begin
            r_cnt <= r_cnt - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_data <= i_load.data;
        end else if (w_take) begin
            r_data <= {8'b0, r_data[39:8]};
        end
    end

    assign o_packed_byte = r_data[7:0];
    assign o_group_end   = (r_cnt == 3'd1);

    `CCP_ASSERT_RST(a_cnt_range, i_clk, i_rst_n, r_cnt <= ccp_pkg::BYTES_TEN)
    `CCP_ASSERT_RST(a_load_size, i_clk, i_rst_n,
        i_load.valid |-> (i_load.cnt == ccp_pkg::BYTES_TEN || i_load.cnt == ccp_pkg::BYTES_FOUR))
    `CCP_ASSERT_RST(a_load_count, i_clk, i_rst_n, w_load |=> (r_cnt == $past(i_load.cnt)))
    `CCP_ASSERT_RST(a_drain_empty, i_clk, i_rst_n,
        (w_take && r_cnt == 3'd1 && !i_load.valid) |=> !o_valid)

endmodule

FILE: hw/rtl/coefficient_compress_pack.sv
// Streaming compressor and bit packer for coefficients modulo 3329.
// Input channel: i_valid / o_stall carry one signed 16-bit coefficient per word.
// Output channel: o_valid / i_stall carry one packed byte per word; o_group_end
// marks the last byte of a group (five bytes per four coefficients in 10-bit
// mode, one byte per two coefficients in 4-bit mode, low value in low bits).
// Config: i_cfg_wr_en writes i_cfg_wr_data into the mode bit (1 = 10-bit) and
// drops any partial group; write only while the block is empty.
// Path: the word that completes a group passes the modq input register, the
// modq quotient register, the remainder/compress register and the packer's
// load into the byte serializer, which then offers the group's first byte.
// Throughput: one coefficient per cycle in 4-bit mode while i_stall is low;
// in 10-bit mode the one-byte output port sets the pace, five bytes per group.
// Reset (synchronous, active low) empties the pipeline, clears the partial
// group and selects 10-bit mode. A stalled receiver holds the current byte;
// the pipeline keeps taking words until a completed group cannot be handed
// to the serializer, then o_stall rises.
module coefficient_compress_pack (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_wr_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [15:0] i_coefficient,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_packed_byte,
    output logic        o_group_end
);

    logic           r_ten_bit_mode;
    logic           w_adv;
    logic           w_can_load;
    logic           w_s2_valid;
    logic [16:0]    w_s2_u;
    logic [4:0]     w_s2_q;
    logic           w_s3_valid;
    logic [9:0]     w_s3_c;
    ccp_pkg::t_load w_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ten_bit_mode <= 1'b1;
        end else if (i_cfg_wr_en) begin
            r_ten_bit_mode <= i_cfg_wr_data;
        end
    end

    // whole pipeline holds only when a finished group finds the serializer busy
    assign w_adv   = !(w_load.valid && !w_can_load);
    assign o_stall = !w_adv;

    ccp_modq u_modq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_adv         (w_adv),
        .i_valid       (i_valid),
        .i_coefficient (i_coefficient),
        .o_valid       (w_s2_valid),
        .o_u           (w_s2_u),
        .o_q           (w_s2_q)
    );

    ccp_compress u_compress (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_adv          (w_adv),
        .i_valid        (w_s2_valid),
        .i_u            (w_s2_u),
        .i_q            (w_s2_q),
        .i_ten_bit_mode (r_ten_bit_mode),
        .o_valid        (w_s3_valid),
        .o_c            (w_s3_c)
    );

    ccp_pack u_pack (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_adv          (w_adv),
        .i_clear        (i_cfg_wr_en),
        .i_valid        (w_s3_valid),
        .i_c            (w_s3_c),
        .i_ten_bit_mode (r_ten_bit_mode),
        .o_load         (w_load)
    );

    ccp_serial u_serial (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (w_load),
        .o_can_load    (w_can_load),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_packed_byte (o_packed_byte),
        .o_group_end   (o_group_end)
    );

endmodule

FILE: dv/tb.sv
// testbench for coefficient_compress_pack: random and directed coefficient words,
// a self-checking prediction of the packed byte stream, random idling on both sides
// depends on ccp_pkg and the coefficient_compress_pack rtl
`timescale 1ns / 100ps

module tb;

    localparam int MODULUS       = int'(ccp_pkg::Q_MOD);
    localparam bit MODE_FOUR     = 1'b0;
    localparam bit MODE_TEN      = 1'b1;
    localparam int SETTLE_CYCLES = 10;
    localparam int QUIET_LIMIT   = 4000;
    localparam int REPORT_LIMIT  = 10;
    localparam int RANDOM_PHASES = 8;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_packed_word;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_wr_en = 1'b0;
    logic        i_cfg_wr_data = 1'b0;
    logic        i_valid = 1'b0;
    logic [15:0] i_coefficient = 16'd0;
    logic        i_stall = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [7:0]  o_packed_byte;
    logic        o_group_end;

    coefficient_compress_pack uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_coefficient (i_coefficient),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_packed_byte (o_packed_byte),
        .o_group_end   (o_group_end)
    );

    initial forever #5 i_clk = ~i_clk;

    // predictor state, mirrors the block after reset
    bit          model_ten  = MODE_TEN;
    logic [1:0]  model_slot = 2'd0;
    logic [29:0] model_held = 30'd0;

    logic [15:0]  coef_queue[$];
    t_packed_word expected_bytes[$];
    int           mismatches = 0;

    function automatic logic [11:0] reduce_coef(input logic [15:0] coef);
        int v;
        int r;
        v = int'(signed'(coef));
        r = v % MODULUS;
        if (r < 0) r += MODULUS;
        return r[11:0];
    endfunction

    function automatic logic [9:0] compress_coef(input logic [11:0] t, input bit ten);
        int unsigned tt;
        int unsigned n;
        tt = 32'(t);
        if (ten) begin
            n = ((tt << 10) + ccp_pkg::HALF_Q) / ccp_pkg::Q_MOD;
            return n[9:0];
        end else begin
            n = ((tt << 4) + ccp_pkg::HALF_Q) / ccp_pkg::Q_MOD;
            return {6'd0, n[3:0]};
        end
    endfunction

    function automatic void predict_packing(input logic [15:0] coef);
        logic [9:0]   c;
        logic [39:0]  all_bits;
        t_packed_word w;
        c = compress_coef(reduce_coef(coef), model_ten);
        if (model_ten) begin
            if (model_slot < ccp_pkg::SLOT_LAST) begin
                model_held = model_held | (30'(c) << (10 * model_slot));
                model_slot = model_slot + 2'd1;
            end else begin
                all_bits = {c, model_held};
                for (int k = 0; k < 5; k++) begin
                    w.data = all_bits[8*k +: 8];
                    w.last = (k == 4);
                    expected_bytes.push_back(w);
                end
                model_slot = 2'd0;
                model_held = 30'd0;
            end
        end else begin
            if (!model_slot[0]) begin
                model_held = 30'(c[3:0]);
                model_slot = 2'd1;
            end else begin
                w.data = {c[3:0], model_held[3:0]};
                w.last = 1'b1;
                expected_bytes.push_back(w);
                model_slot = 2'd0;
                model_held = 30'd0;
            end
        end
    endfunction

    function automatic logic [15:0] pick_coefficient();
        int t;
        int k;
        case ($urandom_range(0, 5))
            0, 1: return 16'($urandom);
            2: return 16'($urandom_range(0, MODULUS - 1));
            3: begin
                // near the rounding points and the top of the range, shifted by multiples of q
                t = ($urandom_range(0, 1) == 0) ? $urandom_range(1600, 1730)
                                                : $urandom_range(3200, MODULUS - 1);
                k = int'($urandom_range(0, 17)) - 9;
                return 16'(t + k * MODULUS);
            end
            4: begin
                case ($urandom_range(0, 6))
                    0: return 16'h8000;
                    1: return 16'h7FFF;
                    2: return 16'hFFFF;
                    3: return 16'd0;
                    4: return 16'(MODULUS - 1);
                    5: return 16'(MODULUS);
                    default: return 16'(-MODULUS);
                endcase
            end
            default: return 16'(int'($urandom_range(0, 2 * MODULUS)) - MODULUS);
        endcase
    endfunction

    // sender: bursts of words with random gaps
    int burst_left = 1;
    int gap_left   = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) predict_packing(i_coefficient);
            if (!i_valid || !o_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (coef_queue.size() > 0) begin
                    i_coefficient <= coef_queue.pop_front();
                    i_valid <= 1'b1;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 12);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: stall style changes every so often, one style never stalls
    int stall_style = 0;
    int style_left  = 0;
    int stall_run   = 0;

    always @(posedge i_clk) begin
        t_packed_word want;
        bit           next_stall;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_bytes.size() == 0) begin
                    if (mismatches < REPORT_LIMIT)
                        $display("unexpected byte %h end %b at %0t",
                                 o_packed_byte, o_group_end, $realtime);
                    mismatches++;
                end else begin
                    want = expected_bytes.pop_front();
                    if (o_packed_byte !== want.data || o_group_end !== want.last) begin
                        if (mismatches < REPORT_LIMIT)
                            $display("byte mismatch at %0t: expected %h end %b, got %h end %b",
                                     $realtime, want.data, want.last,
                                     o_packed_byte, o_group_end);
                        mismatches++;
                    end
                end
            end
            if (style_left == 0) begin
                stall_style = $urandom_range(0, 2);
                style_left = $urandom_range(40, 200);
            end else begin
                style_left--;
            end
            case (stall_style)
                0: next_stall = 1'b0;
                1: next_stall = ($urandom_range(0, 3) == 0);
                default: begin
                    if (stall_run > 0) begin
                        stall_run--;
                        next_stall = 1'b1;
                    end else if ($urandom_range(0, 5) == 0) begin
                        stall_run = $urandom_range(1, 12);
                        next_stall = 1'b1;
                    end else begin
                        next_stall = 1'b0;
                    end
                end
            endcase
            i_stall <= next_stall;
        end
    end

    // watchdog on cycles without any word moving
    int quiet_cycles = 0;

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || i_cfg_wr_en)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic wait_drained();
        do @(posedge i_clk);
        while (coef_queue.size() != 0 || i_valid || expected_bytes.size() != 0);
        // a partial group may still sit in the pipeline
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // a mode write also drops any partial group
    task automatic write_mode(input bit ten);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= ten;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        model_ten = ten;
        model_slot = 2'd0;
        model_held = 30'd0;
    endtask

    initial begin
        bit mode;
        int count;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // 10-bit mode out of reset: extremes, wrap of 3328 to zero, rounding points,
        // then a partial group left behind
        coef_queue = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF,
                       16'd3328, 16'd3329, 16'(-3329), 16'd1664,
                       16'd1665, 16'(-1664), 16'd1, 16'd3327,
                       16'd1000, 16'(-2000)};
        wait_drained();
        write_mode(MODE_FOUR);

        // 4-bit mode: extremes and nibble wrap, then a partial group
        coef_queue = '{16'h8000, 16'h7FFF, 16'h0000, 16'd3328,
                       16'd1664, 16'hFFFF, 16'd208, 16'd3121, 16'd5};
        wait_drained();
        // rewriting the same mode still drops the held nibble
        write_mode(MODE_FOUR);

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            mode = (p % 2 == 0) ? MODE_TEN : MODE_FOUR;
            write_mode(mode);
            count = $urandom_range(36, 54);
            for (int i = 0; i < count; i++) coef_queue.push_back(pick_coefficient());
            wait_drained();
        end

        if (mismatches == 0 && expected_bytes.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

FILE: coefficient_compress_pack.f
+incdir+hw/rtl
hw/rtl/ccp_pkg.sv
hw/rtl/ccp_modq.sv
hw/rtl/ccp_compress.sv
hw/rtl/ccp_pack.sv
hw/rtl/ccp_serial.sv
hw/rtl/coefficient_compress_pack.sv
dv/tb.sv
